### rtl/pulse_speed_odometer_macros.svh
// Assertion macros shared by the pulse speed odometer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PULSE_SPEED_ODOMETER_MACROS_SVH
`define PULSE_SPEED_ODOMETER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pulse speed odometer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pulse speed odometer: next-cycle check failed");

`endif

### rtl/psodo_pkg.sv
// Package for the pulse speed odometer: widths, reset values and register indexes.
// No dependencies; used by pulse_speed_odometer, odometer_checker and the testbench.
package psodo_pkg;

   localparam int COUNT_BITS = 16;

   localparam int STABLE_W = 8;
   localparam int TICK_W   = 16;
   localparam int DIST_W   = 16;
   localparam int SCALE_W  = 16;
   localparam int PULSE_W  = 16;
   localparam int SPEED_W  = 24;
   localparam int ODO_W    = 32;

   localparam int PROD_W  = COUNT_BITS + SCALE_W;
   localparam int SHIFT_W = PROD_W - 8;
   localparam int SAT_W   = (SHIFT_W > SPEED_W) ? SHIFT_W : SPEED_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = PULSE_W + SPEED_W + ODO_W;
   localparam int RSP_USER_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_STABLE_SAMPLES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PULSES_PER_STEP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SCALE     = 2'd3;

   localparam logic [STABLE_W-1:0] STABLE_SAMPLES_RESET  = 8'd5;
   localparam logic [TICK_W-1:0]   WINDOW_TICKS_RESET    = 16'd20000;
   localparam logic [DIST_W-1:0]   PULSES_PER_STEP_RESET = 16'd8530;
   localparam logic [SCALE_W-1:0]  SPEED_SCALE_RESET     = 16'd1380;

   localparam logic [ODO_W-1:0]   STEP_METRES = 32'd100;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 24'hFFFFFF;

   typedef struct packed {
      logic                window_done;
      logic [PULSE_W-1:0]  window_pulses;
      logic [SPEED_W-1:0]  speed_q8;
      logic [ODO_W-1:0]    odometer_m;
      logic                odometer_save;
   } result_type;

endpackage

### rtl/pulse_speed_odometer.sv
// Pulse speed odometer top level: debounce, pulse count, speed window and odometer.
// Depends on psodo_pkg and pulse_speed_odometer_macros.svh.
//
// Takes up to one pin sample per cycle on the req channel and returns exactly one result
// per sample on the rsp channel. A sample waits in an input register, then a single
// pass of logic (counters, one 16 by 16 multiply for the speed) writes the result
// register; throughput is one sample per cycle while rsp_tready stays high. The
// input register and the result register hold one transfer each, so a stalled
// output still lets one more sample in. The user must write registers through the
// csr port only while the block is idle; the block does not enforce this. The csr
// port is always ready.
`include "pulse_speed_odometer_macros.svh"

module pulse_speed_odometer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low: pulse_level, zero fill.
   input  logic [psodo_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: window_pulses, speed_q8, odometer_m.
   output logic [psodo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Bits from low: window_done, odometer_save.
   output logic [psodo_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psodo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psodo_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [psodo_pkg::STABLE_W-1:0] stable_samples_ff;
   logic [psodo_pkg::TICK_W-1:0]   window_ticks_ff;
   logic [psodo_pkg::DIST_W-1:0]   pulses_per_step_ff;
   logic [psodo_pkg::SCALE_W-1:0]  speed_scale_ff;

   logic                            in_valid_ff;
   logic                            level_ff;

   logic                              last_level_ff, last_level_in;
   logic [psodo_pkg::STABLE_W-1:0]    stable_run_ff, stable_run_in;
   logic                              pulse_taken_ff, pulse_taken_in;
   logic [psodo_pkg::TICK_W-1:0]      tick_count_ff, tick_count_in;
   logic [psodo_pkg::COUNT_BITS-1:0]  pulse_count_ff, pulse_count_in;
   logic [psodo_pkg::DIST_W-1:0]      dist_pulses_ff, dist_pulses_in;
   logic [psodo_pkg::ODO_W-1:0]       odometer_ff, odometer_in;

   logic                              out_valid_ff;
   psodo_pkg::result_type             result_ff, result_in;

   logic                              advance;
   logic [psodo_pkg::COUNT_BITS-1:0]  pulse_inc;
   logic [psodo_pkg::PROD_W-1:0]      product;
   logic [psodo_pkg::SAT_W-1:0]       speed_wide;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_samples_ff  <= psodo_pkg::STABLE_SAMPLES_RESET;
         window_ticks_ff    <= psodo_pkg::WINDOW_TICKS_RESET;
         pulses_per_step_ff <= psodo_pkg::PULSES_PER_STEP_RESET;
         speed_scale_ff     <= psodo_pkg::SPEED_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            psodo_pkg::REG_STABLE_SAMPLES: begin
               stable_samples_ff <= csr_data[psodo_pkg::STABLE_W-1:0];
            end
            psodo_pkg::REG_WINDOW_TICKS: begin
               window_ticks_ff <= csr_data[psodo_pkg::TICK_W-1:0];
            end
            psodo_pkg::REG_PULSES_PER_STEP: begin
               pulses_per_step_ff <= csr_data[psodo_pkg::DIST_W-1:0];
            end
            psodo_pkg::REG_SPEED_SCALE: begin
               speed_scale_ff <= csr_data[psodo_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         level_ff <= req_tdata[0];
      end
   end

   always_comb begin
      last_level_in  = last_level_ff;
      stable_run_in  = stable_run_ff;
      pulse_taken_in = pulse_taken_ff;
      tick_count_in  = tick_count_ff + 1'b1;
      pulse_inc      = pulse_count_ff;
      dist_pulses_in = dist_pulses_ff;
      odometer_in    = odometer_ff;
      result_in      = '0;

      if (level_ff == last_level_ff) begin
         stable_run_in = stable_run_ff + 1'b1;
         if (stable_run_in >= stable_samples_ff) begin
            stable_run_in = '0;
            if (level_ff && !pulse_taken_ff) begin
               pulse_inc      = pulse_count_ff + 1'b1;
               dist_pulses_in = dist_pulses_ff + 1'b1;
               if (dist_pulses_in >= pulses_per_step_ff) begin
                  dist_pulses_in          = '0;
                  odometer_in             = odometer_ff + psodo_pkg::STEP_METRES;
                  result_in.odometer_save = 1'b1;
               end
               pulse_taken_in = 1'b1;
            end
         end
      end else begin
         last_level_in  = level_ff;
         stable_run_in  = '0;
         pulse_taken_in = 1'b0;
      end

      product    = psodo_pkg::PROD_W'(pulse_inc) * psodo_pkg::PROD_W'(speed_scale_ff);
      speed_wide = psodo_pkg::SAT_W'(product[psodo_pkg::PROD_W-1:8]);
      pulse_count_in = pulse_inc;

      if (tick_count_in >= window_ticks_ff) begin
         result_in.window_done   = 1'b1;
         result_in.window_pulses = psodo_pkg::PULSE_W'(pulse_inc);
         if (speed_wide > psodo_pkg::SAT_W'(psodo_pkg::SPEED_MAX)) begin
            result_in.speed_q8 = psodo_pkg::SPEED_MAX;
         end else begin
            result_in.speed_q8 = speed_wide[psodo_pkg::SPEED_W-1:0];
         end
         pulse_count_in = '0;
         tick_count_in  = '0;
      end

      result_in.odometer_m = odometer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b0;
         stable_run_ff  <= '0;
         pulse_taken_ff <= 1'b0;
         tick_count_ff  <= '0;
         pulse_count_ff <= '0;
         dist_pulses_ff <= '0;
         odometer_ff    <= '0;
      end else if (advance) begin
         last_level_ff  <= last_level_in;
         stable_run_ff  <= stable_run_in;
         pulse_taken_ff <= pulse_taken_in;
         tick_count_ff  <= tick_count_in;
         pulse_count_ff <= pulse_count_in;
         dist_pulses_ff <= dist_pulses_in;
         odometer_ff    <= odometer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {result_ff.odometer_m, result_ff.speed_q8, result_ff.window_pulses};
   assign rsp_tuser  = {result_ff.odometer_save, result_ff.window_done};

   `PSO_ASSERT_IMP(a_taken_only_high, clock, reset, pulse_taken_ff, last_level_ff)
   `PSO_ASSERT_IMP(a_ready_when_empty, clock, reset, !out_valid_ff, req_tready)
   `PSO_ASSERT_IMP(a_idle_window_zero, clock, reset, out_valid_ff && !result_ff.window_done,
                   result_ff.window_pulses == '0 && result_ff.speed_q8 == '0)
   `PSO_ASSERT_NEXT(a_odo_moves_on_save, clock, reset, !(advance && result_in.odometer_save),
                    $stable(odometer_ff))

endmodule

### sim/odometer_checker.sv
// Checker for the pulse speed odometer: watches the req, rsp and csr channels,
// predicts each result from its own copy of the registers and state, and compares.
// Depends on psodo_pkg; instantiated by tb_pulse_speed_odometer beside the block.
`timescale 1ns / 1ps

module odometer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // Bits from low: pulse_level, zero fill.
   input  logic [psodo_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: window_pulses, speed_q8, odometer_m.
   input  logic [psodo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Bits from low: window_done, odometer_save.
   input  logic [psodo_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [psodo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psodo_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                  error_count,
   output int                                  pending,
   output int                                  windows_seen,
   output int                                  saves_seen
);
   import psodo_pkg::*;

   logic [STABLE_W-1:0]   cfg_stable;
   logic [TICK_W-1:0]     cfg_window;
   logic [DIST_W-1:0]     cfg_pps;
   logic [SCALE_W-1:0]    cfg_scale;

   logic                  last_level;
   logic [STABLE_W-1:0]   stable_run;
   logic                  pulse_taken;
   logic [TICK_W-1:0]     tick_count;
   logic [COUNT_BITS-1:0] pulse_count;
   logic [DIST_W-1:0]     distance_pulses;
   logic [ODO_W-1:0]      odometer;

   result_type expected_results[$];
   int         mismatches = 0;
   int         checked = 0;
   int         windows = 0;
   int         saves = 0;

   function automatic result_type next_tick(input logic level);
      result_type           r;
      logic [PROD_W-1:0]    product;
      logic [PROD_W-1:0]    scaled;
      r = '0;
      tick_count = tick_count + 1'b1;
      if (level == last_level) begin
         stable_run = stable_run + 1'b1;
         if (stable_run >= cfg_stable) begin
            stable_run = '0;
            if (level && !pulse_taken) begin
               pulse_count     = pulse_count + 1'b1;
               distance_pulses = distance_pulses + 1'b1;
               if (distance_pulses >= cfg_pps) begin
                  distance_pulses = '0;
                  odometer        = odometer + STEP_METRES;
                  r.odometer_save = 1'b1;
               end
               pulse_taken = 1'b1;
            end
         end
      end else begin
         last_level  = level;
         stable_run  = '0;
         pulse_taken = 1'b0;
      end
      if (tick_count >= cfg_window) begin
         r.window_done   = 1'b1;
         r.window_pulses = pulse_count[PULSE_W-1:0];
         product         = PROD_W'(pulse_count);
         product         = product * PROD_W'(cfg_scale);
         scaled          = product >> 8;
         r.speed_q8      = (scaled > SPEED_MAX) ? SPEED_MAX : scaled[SPEED_W-1:0];
         pulse_count     = '0;
         tick_count      = '0;
      end
      r.odometer_m = odometer;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type actual;
      result_type wanted;
      if (reset) begin
         cfg_stable      = STABLE_SAMPLES_RESET;
         cfg_window      = WINDOW_TICKS_RESET;
         cfg_pps         = PULSES_PER_STEP_RESET;
         cfg_scale       = SPEED_SCALE_RESET;
         last_level      = 1'b0;
         stable_run      = '0;
         pulse_taken     = 1'b0;
         tick_count      = '0;
         pulse_count     = '0;
         distance_pulses = '0;
         odometer        = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STABLE_SAMPLES:  cfg_stable = csr_data[STABLE_W-1:0];
               REG_WINDOW_TICKS:    cfg_window = csr_data[TICK_W-1:0];
               REG_PULSES_PER_STEP: cfg_pps    = csr_data[DIST_W-1:0];
               REG_SPEED_SCALE:     cfg_scale  = csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(next_tick(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            actual.window_done   = rsp_tuser[0];
            actual.odometer_save = rsp_tuser[1];
            actual.window_pulses = rsp_tdata[PULSE_W-1:0];
            actual.speed_q8      = rsp_tdata[PULSE_W +: SPEED_W];
            actual.odometer_m    = rsp_tdata[PULSE_W+SPEED_W +: ODO_W];
            if (actual.window_done === 1'b1)
               windows++;
            if (actual.odometer_save === 1'b1)
               saves++;
            if (expected_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("result %0d with no sample outstanding", checked);
                  $display("  actual   done=%0b pulses=%0d speed=%0d odo=%0d save=%0b",
                           actual.window_done, actual.window_pulses,
                           actual.speed_q8, actual.odometer_m, actual.odometer_save);
               end
               mismatches++;
            end else begin
               wanted = expected_results.pop_front();
               if (actual !== wanted) begin
                  if (mismatches < 10) begin
                     $display("result %0d mismatch", checked);
                     $display("  expected done=%0b pulses=%0d speed=%0d odo=%0d save=%0b",
                              wanted.window_done, wanted.window_pulses,
                              wanted.speed_q8, wanted.odometer_m, wanted.odometer_save);
                     $display("  actual   done=%0b pulses=%0d speed=%0d odo=%0d save=%0b",
                              actual.window_done, actual.window_pulses,
                              actual.speed_q8, actual.odometer_m, actual.odometer_save);
                  end
                  mismatches++;
               end
            end
            checked++;
         end
      end
      error_count  <= mismatches;
      pending      <= expected_results.size();
      windows_seen <= windows;
      saves_seen   <= saves;
   end

endmodule

### sim/tb_pulse_speed_odometer.sv
// Testbench top for pulse_speed_odometer: clock, reset, pin-sample stimulus,
// register writes, random back-pressure and the verdict.
// Depends on psodo_pkg, pulse_speed_odometer and odometer_checker.
`timescale 1ns / 1ps

module tb_pulse_speed_odometer;
   import psodo_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_PERCENT   = 31;
   localparam int CALM_FROM      = 900;
   localparam int CALM_TO        = 1150;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 60;
   localparam int RANDOM_PHASES  = 8;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = REG_STABLE_SAMPLES;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   int error_count;
   int pending;
   int windows_seen;
   int saves_seen;
   int items_sent = 0;
   int results_taken = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int cur_stable = 5;
   int phases = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pulse_speed_odometer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   odometer_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .pending      (pending),
      .windows_seen (windows_seen),
      .saves_seen   (saves_seen)
   );

   always @(posedge clock) begin
      if (req_tvalid && req_tready)
         items_sent <= items_sent + 1;
      if (rsp_tvalid && rsp_tready)
         results_taken <= results_taken + 1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_pulse_speed_odometer: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver holds off once for a long stretch so the block fills up.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && results_taken >= HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else if (results_taken >= CALM_FROM && results_taken < CALM_TO) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_level(input logic level);
      logic [REQ_DATA_W-1:0] word;
      word    = '0;
      word[0] = level;
      @(negedge clock);
      while (!(items_sent >= CALM_FROM && items_sent < CALM_TO) &&
             $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_bits(input logic [31:0] pattern, input int count);
      for (int i = 0; i < count; i++)
         send_level(pattern[i]);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [STABLE_W-1:0] stable,
                            input logic [TICK_W-1:0] window,
                            input logic [DIST_W-1:0] pps,
                            input logic [SCALE_W-1:0] scale);
      write_reg(REG_STABLE_SAMPLES, {{(CSR_DATA_W-STABLE_W){1'b0}}, stable});
      write_reg(REG_WINDOW_TICKS, window);
      write_reg(REG_PULSES_PER_STEP, pps);
      write_reg(REG_SPEED_SCALE, scale);
      cur_stable = int'(stable);
      phases++;
   endtask

   // Mostly clean high and low runs long enough to qualify, with glitches
   // and short bursts of random samples mixed in.
   task automatic run_pulse_train(input int count);
      int   sent;
      int   run;
      int   pick;
      logic level;
      sent  = 0;
      level = 1'($urandom_range(1));
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            level = !level;
            run   = cur_stable + 1 + $urandom_range(3);
            repeat (run) begin
               send_level(level);
               sent++;
            end
         end else if (pick < 90) begin
            send_level(!level);
            sent++;
         end else begin
            run = $urandom_range(1, 4);
            repeat (run) begin
               send_level(1'($urandom_range(1)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [STABLE_W-1:0] stable;
      logic [TICK_W-1:0]   window;
      logic [DIST_W-1:0]   pps;
      logic [SCALE_W-1:0]  scale;
      int                  errors;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a low run that qualifies without a pulse, then one pulse.
      send_bits(32'b101111111000000, 15);
      settle();
      // Window lowered below the running tick count, single-sample debounce.
      configure(8'd1, 16'd3, 16'd1, 16'hFFFF);
      send_bits(32'b1001, 4);
      settle();
      // All-zero registers: every tick closes a window, every pulse steps.
      configure(8'd0, 16'd0, 16'd0, 16'd0);
      send_bits(32'b11011, 5);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         stable = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom_range(1, 6));
         window = (p == 3) ? 16'd0 :
                  (p == 2) ? 16'($urandom_range(100, 400)) : 16'($urandom_range(1, 40));
         pps    = (p == 4) ? 16'd0 : (p == 5) ? 16'hFFFF : 16'($urandom_range(1, 6));
         scale  = (p == 6) ? 16'd0 : (p == 7) ? 16'hFFFF : 16'($urandom_range(65535));
         configure(stable, window, pps, scale);
         run_pulse_train((stable == 8'd255) ? 400 : 130);
         settle();
      end

      // One window at the fastest pulse rate the debounce allows.
      configure(8'd0, 16'd96, 16'hFFFF, 16'hFFFF);
      repeat (32) send_bits(32'b110, 3);
      settle();
      // Step size lowered far below the distance count built up above.
      configure(8'd2, 16'd16, 16'd1, 16'd1380);
      run_pulse_train(60);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      errors = error_count + pending;
      $display("%0d samples in %0d register settings, %0d results checked", items_sent,
               phases + 1, results_taken);
      $display("%0d windows closed, %0d odometer saves, %0d failures", windows_seen,
               saves_seen, errors);
      if (errors == 0) begin
         $display("tb_pulse_speed_odometer: clean");
      end else begin
         $display("tb_pulse_speed_odometer: errors");
      end
      $finish;
   end

endmodule
